// ===== rtl/core/bls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line stepper package
// Operation codes shared by the front end and the back end.
// ----------------------------------------------------------------------------
package bls_pkg;

   // Kind of request carried in tuser
   typedef enum logic {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } bls_op_type;

endpackage

// ===== rtl/core/bresenham_line_stepper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line stepper
// Integer line rasteriser for all octants: a start transaction loads the
// endpoints and returns the first pixel, each advance returns the next one.
// ----------------------------------------------------------------------------
// Every request transaction gives exactly one response transaction. The block
// takes one request per cycle, sustained, while rsp_tready stays high. Each
// request is registered in the command queue, then the line state update
// loads its pixel into the output register. The rate is set by the pixel
// update in the back end, a compare of the error term against both spans and
// two small adds on registered state. rsp_tlast marks the endpoint; advancing
// past the end, or before any start, repeats the current pixel with tlast high.
// ----------------------------------------------------------------------------
module bresenham_line_stepper #(
   parameter int COORD_BITS = 12
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // from_x, from_y, to_x, to_y, zero pad
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]       req_tdata,
   // func
   input  bls_pkg::bls_op_type                     req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // pixel_x, pixel_y, zero pad
   output logic [((2*COORD_BITS+7)/8)*8-1:0]       rsp_tdata,
   output logic                                    rsp_tlast
);
   import bls_pkg::*;

   localparam int CmdBits = 7*COORD_BITS + 5;
   localparam int RspBits = ((2*COORD_BITS+7)/8)*8;

   logic [CmdBits-1:0]    front_cmd;
   logic [CmdBits-1:0]    queue_cmd;
   logic                  queue_valid;
   logic                  back_ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;

   // Classify and prepare the request
   bls_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .op     (req_tuser),
      .from_x (req_tdata[COORD_BITS-1:0]),
      .from_y (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .to_x   (req_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .to_y   (req_tdata[4*COORD_BITS-1:3*COORD_BITS]),
      .cmd    (front_cmd)
   );

   // Decouple front from back
   bls_cmd_queue #(
      .WIDTH(CmdBits)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_data  (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (back_ready),
      .pop_data   (queue_cmd)
   );

   // Step the line and drive the response
   bls_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd_ready (back_ready),
      .cmd       (queue_cmd),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_x     (pixel_x),
      .out_y     (pixel_y),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = RspBits'({pixel_y, pixel_x});

endmodule

// ===== rtl/core/bls_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line stepper front end
// Classifies a request and works out spans, step directions and the
// initial error term for a start request, packing it as one command word.
// ----------------------------------------------------------------------------
module bls_front #(
   parameter int COORD_BITS = 12
) (
   input  bls_pkg::bls_op_type              op,
   input  logic [COORD_BITS-1:0]            from_x,
   input  logic [COORD_BITS-1:0]            from_y,
   input  logic [COORD_BITS-1:0]            to_x,
   input  logic [COORD_BITS-1:0]            to_y,
   output logic [7*COORD_BITS+5-1:0]        cmd
);
   import bls_pkg::*;

   localparam int ErrBits = COORD_BITS + 2;

   logic                  x_lt;
   logic                  y_lt;
   logic [COORD_BITS-1:0] span_x;
   logic [COORD_BITS-1:0] span_y;
   logic [ErrBits-1:0]    half_x;
   logic [ErrBits-1:0]    half_y;
   logic [ErrBits-1:0]    err_init;

   // Absolute spans and directions
   assign x_lt   = from_x < to_x;
   assign y_lt   = from_y < to_y;
   assign span_x = x_lt ? (to_x - from_x) : (from_x - to_x);
   assign span_y = y_lt ? (to_y - from_y) : (from_y - to_y);

   // Halve the dominant term, truncating toward zero
   assign half_x   = {3'b000, span_x[COORD_BITS-1:1]};
   assign half_y   = {3'b000, span_y[COORD_BITS-1:1]};
   assign err_init = (span_x > span_y) ? half_x : (ErrBits'(0) - half_y);

   // Pack the command, operation code in the top bit
   assign cmd = {op, from_x, from_y, to_x, to_y, span_x, span_y, !x_lt, !y_lt, err_init};

endmodule

// ===== rtl/core/bls_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line stepper command queue
// Two-entry queue that lets the front end and the back end stall apart.
// ----------------------------------------------------------------------------
module bls_cmd_queue #(
   parameter int WIDTH = 89
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int Depth = 2;
   localparam int PtrBits = $clog2(Depth);

   logic [WIDTH-1:0]   slot_ff [Depth];
   logic [PtrBits-1:0] wr_ptr_ff;
   logic [PtrBits-1:0] wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff;
   logic [PtrBits-1:0] rd_ptr_in;
   logic [PtrBits:0]   count_ff;
   logic [PtrBits:0]   count_in;
   logic               push;
   logic               pop;

   assign push_ready = count_ff != (PtrBits + 1)'(Depth);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed transaction
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/bls_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bresenham line stepper back end
// Holds the line state, carries out start and advance commands and drives
// the registered pixel output.
// ----------------------------------------------------------------------------
module bls_back #(
   parameter int COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  logic [7*COORD_BITS+5-1:0]     cmd,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [COORD_BITS-1:0]         out_x,
   output logic [COORD_BITS-1:0]         out_y,
   output logic                          out_last
);
   import bls_pkg::*;

   localparam int ErrBits = COORD_BITS + 2;

   bls_op_type            c_op;
   logic                  c_op_bit;
   logic [COORD_BITS-1:0] c_from_x;
   logic [COORD_BITS-1:0] c_from_y;
   logic [COORD_BITS-1:0] c_to_x;
   logic [COORD_BITS-1:0] c_to_y;
   logic [COORD_BITS-1:0] c_span_x;
   logic [COORD_BITS-1:0] c_span_y;
   logic                  c_dir_x_neg;
   logic                  c_dir_y_neg;
   logic [ErrBits-1:0]    c_err;

   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff, pos_y_in;
   logic [COORD_BITS-1:0] goal_x_ff, goal_x_in;
   logic [COORD_BITS-1:0] goal_y_ff, goal_y_in;
   logic [COORD_BITS-1:0] span_x_ff, span_x_in;
   logic [COORD_BITS-1:0] span_y_ff, span_y_in;
   logic                  dir_x_neg_ff, dir_x_neg_in;
   logic                  dir_y_neg_ff, dir_y_neg_in;
   logic signed [ErrBits-1:0] err_ff, err_in;

   logic                  out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0] out_x_ff;
   logic [COORD_BITS-1:0] out_y_ff;
   logic                  out_last_ff;

   logic                      fire;
   logic                      at_goal;
   logic signed [ErrBits-1:0] span_x_s;
   logic signed [ErrBits-1:0] span_y_s;
   logic                      step_x;
   logic                      step_y;

   assign {c_op_bit, c_from_x, c_from_y, c_to_x, c_to_y, c_span_x, c_span_y,
           c_dir_x_neg, c_dir_y_neg, c_err} = cmd;
   assign c_op = bls_op_type'(c_op_bit);

   // Take a command whenever the output register is free or draining
   assign cmd_ready = !out_valid_ff || out_ready;
   assign fire      = cmd_valid && cmd_ready;

   assign at_goal  = (pos_x_ff == goal_x_ff) && (pos_y_ff == goal_y_ff);
   assign span_x_s = $signed({2'b00, span_x_ff});
   assign span_y_s = $signed({2'b00, span_y_ff});
   assign step_x   = !at_goal && (err_ff > -span_x_s);
   assign step_y   = !at_goal && (err_ff < span_y_s);

   // Next line state
   always_comb begin
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      goal_x_in    = goal_x_ff;
      goal_y_in    = goal_y_ff;
      span_x_in    = span_x_ff;
      span_y_in    = span_y_ff;
      dir_x_neg_in = dir_x_neg_ff;
      dir_y_neg_in = dir_y_neg_ff;
      err_in       = err_ff;
      case (c_op)
         OP_START: begin
            pos_x_in     = c_from_x;
            pos_y_in     = c_from_y;
            goal_x_in    = c_to_x;
            goal_y_in    = c_to_y;
            span_x_in    = c_span_x;
            span_y_in    = c_span_y;
            dir_x_neg_in = c_dir_x_neg;
            dir_y_neg_in = c_dir_y_neg;
            err_in       = $signed(c_err);
         end
         OP_ADVANCE: begin
            if (step_x) begin
               pos_x_in = dir_x_neg_ff ? pos_x_ff - 1'b1 : pos_x_ff + 1'b1;
            end
            if (step_y) begin
               pos_y_in = dir_y_neg_ff ? pos_y_ff - 1'b1 : pos_y_ff + 1'b1;
            end
            err_in = err_ff - (step_x ? span_y_s : ErrBits'(0))
                            + (step_y ? span_x_s : ErrBits'(0));
         end
         default: begin
            err_in = err_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         span_x_ff    <= '0;
         span_y_ff    <= '0;
         dir_x_neg_ff <= 1'b0;
         dir_y_neg_ff <= 1'b0;
         err_ff       <= '0;
      end else if (fire) begin
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         goal_x_ff    <= goal_x_in;
         goal_y_ff    <= goal_y_in;
         span_x_ff    <= span_x_in;
         span_y_ff    <= span_y_in;
         dir_x_neg_ff <= dir_x_neg_in;
         dir_y_neg_ff <= dir_y_neg_in;
         err_ff       <= err_in;
      end
   end

   // Output register: hold until taken, load the new pixel on each command
   assign out_valid_in = fire || (out_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_x_ff    <= pos_x_in;
         out_y_ff    <= pos_y_in;
         out_last_ff <= (pos_x_in == goal_x_in) && (pos_y_in == goal_y_in);
      end
   end

   assign out_valid = out_valid_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_last  = out_last_ff;

endmodule

// ===== tb/line_pixel_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel checker
// Watches the request and response streams of the line stepper, rebuilds the
// line state from every accepted request to predict the pixel it must return,
// and compares each accepted response against the oldest predicted pixel.
// ----------------------------------------------------------------------------
module line_pixel_checker #(
   parameter int CW = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   // from_x, from_y, to_x, to_y
   input  logic [4*CW-1:0]      req_tdata,
   // func
   input  bls_pkg::bls_op_type  req_tuser,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // pixel_x, pixel_y
   input  logic [2*CW-1:0]      rsp_tdata,
   input  logic                 rsp_tlast,
   output int                   fault_count,
   output int                   pixels_pending
);
   import bls_pkg::*;

   typedef struct packed {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic          last;
   } line_pixel_type;

   line_pixel_type expected_pixels[$];
   int             faults = 0;

   // Line state as the stepper should hold it
   logic [CW-1:0] cur_x, cur_y;
   logic [CW-1:0] end_x, end_y;
   int            run_x, run_y;
   logic          x_down, y_down;
   int            err_acc;

   assign fault_count    = faults;
   assign pixels_pending = expected_pixels.size();

   // Work out the next pixel for one request and queue it
   task automatic step_line(input bls_op_type op, input logic [4*CW-1:0] ends);
      logic [CW-1:0]  fx, fy, tx, ty;
      int             old_err;
      line_pixel_type px;
      fx = ends[CW-1:0];
      fy = ends[2*CW-1:CW];
      tx = ends[3*CW-1:2*CW];
      ty = ends[4*CW-1:3*CW];
      if (op == OP_START) begin
         cur_x   = fx;
         cur_y   = fy;
         end_x   = tx;
         end_y   = ty;
         x_down  = !(fx < tx);
         y_down  = !(fy < ty);
         run_x   = (fx < tx) ? int'(tx) - int'(fx) : int'(fx) - int'(tx);
         run_y   = (fy < ty) ? int'(ty) - int'(fy) : int'(fy) - int'(ty);
         // Half the dominant span, truncated toward zero
         err_acc = ((run_x > run_y) ? run_x : -run_y) / 2;
      end else if (!(cur_x == end_x && cur_y == end_y)) begin
         old_err = err_acc;
         if (old_err > -run_x) begin
            err_acc -= run_y;
            cur_x = x_down ? cur_x - 1'b1 : cur_x + 1'b1;
         end
         if (old_err < run_y) begin
            err_acc += run_x;
            cur_y = y_down ? cur_y - 1'b1 : cur_y + 1'b1;
         end
      end
      px.x    = cur_x;
      px.y    = cur_y;
      px.last = (cur_x == end_x && cur_y == end_y);
      expected_pixels.insert(expected_pixels.size(), px);
   endtask

   // Compare one response transaction with the oldest prediction
   task automatic check_pixel();
      line_pixel_type want;
      if (expected_pixels.size() == 0) begin
         $error("response with no pixel expected: x %0d y %0d last %0b",
                rsp_tdata[CW-1:0], rsp_tdata[2*CW-1:CW], rsp_tlast);
         faults++;
      end else begin
         want = expected_pixels.pop_front();
         if (rsp_tdata[CW-1:0] !== want.x) begin
            $error("pixel_x: expected %0d, actual %0d", want.x, rsp_tdata[CW-1:0]);
            faults++;
         end
         if (rsp_tdata[2*CW-1:CW] !== want.y) begin
            $error("pixel_y: expected %0d, actual %0d", want.y, rsp_tdata[2*CW-1:CW]);
            faults++;
         end
         if (rsp_tlast !== want.last) begin
            $error("last_point: expected %0b, actual %0b", want.last, rsp_tlast);
            faults++;
         end
      end
   endtask

   // Sample both streams on the clock edge
   always @(posedge clock) begin
      if (reset) begin
         cur_x   = '0;
         cur_y   = '0;
         end_x   = '0;
         end_y   = '0;
         run_x   = 0;
         run_y   = 0;
         x_down  = 1'b0;
         y_down  = 1'b0;
         err_acc = 0;
         expected_pixels.delete();
      end else begin
         if (req_tvalid && req_tready)
            step_line(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            check_pixel();
      end
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line stepper testbench
// Drives start and advance transactions into the line stepper with random
// gaps and response stalls: a few hand-picked lines first, then mostly short
// lines walked to their end and beyond, some long lines cut short and some
// random noise. A separate checker predicts and compares every pixel.
// ----------------------------------------------------------------------------
module tb;
   import bls_pkg::*;

   localparam int CW        = 12;
   localparam int COORD_MAX = (1 << CW) - 1;
   localparam int ITEM_GOAL = 1500;
   localparam int LIMIT     = 1_000_000;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [4*CW-1:0]      req_tdata  = '0;
   bls_op_type           req_tuser  = OP_START;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [2*CW-1:0]      rsp_tdata;
   logic                 rsp_tlast;

   int                   fault_count;
   int                   pixels_pending;
   int                   items_sent  = 0;
   int                   cycle_count = 0;
   logic                 no_idle     = 1'b0;
   int                   stall_left  = 0;
   int                   ready_roll;

   bresenham_line_stepper #(.COORD_BITS(CW)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   line_pixel_checker #(.CW(CW)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .fault_count    (fault_count),
      .pixels_pending (pixels_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // Stall the response side: mostly short stalls, a few long ones
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (no_idle) begin
         rsp_tready <= 1'b1;
      end else begin
         ready_roll = $urandom_range(0, 99);
         if (ready_roll < 70) begin
            rsp_tready <= 1'b1;
         end else if (ready_roll < 95) begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(5, 40);
         end
      end
   end

   function automatic logic [4*CW-1:0] pack_ends(input int fx, fy, tx, ty);
      logic [CW-1:0] a, b, c, d;
      a = fx[CW-1:0];
      b = fy[CW-1:0];
      c = tx[CW-1:0];
      d = ty[CW-1:0];
      return {d, c, b, a};
   endfunction

   function automatic logic [4*CW-1:0] rand_payload();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[4*CW-1:0];
   endfunction

   // Coordinate biased toward the edges of the range
   function automatic int pick_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 0;
      else if (r == 1)
         return COORD_MAX;
      else
         return $urandom_range(0, COORD_MAX);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55)
         return 0;
      else if (r < 88)
         return $urandom_range(1, 3);
      else
         return $urandom_range(4, 30);
   endfunction

   // Present one request transaction and hold it until taken
   task automatic send_item(input bls_op_type op, input logic [4*CW-1:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Start a line and advance it a number of times
   task automatic drive_line(input int fx, fy, tx, ty, steps);
      send_item(OP_START, pack_ends(fx, fy, tx, ty));
      repeat (steps) send_item(OP_ADVANCE, rand_payload());
   endtask

   // Short line with random offsets, folded back into range
   task automatic short_line();
      int fx, fy, tx, ty, dx, dy, n, tail;
      fx = pick_coord();
      fy = pick_coord();
      dx = int'($urandom_range(0, 24)) - 12;
      dy = int'($urandom_range(0, 24)) - 12;
      tx = fx + dx;
      ty = fy + dy;
      if (tx < 0 || tx > COORD_MAX) tx = fx - dx;
      if (ty < 0 || ty > COORD_MAX) ty = fy - dy;
      n = (dx < 0) ? -dx : dx;
      if (((dy < 0) ? -dy : dy) > n) n = (dy < 0) ? -dy : dy;
      tail = $urandom_range(0, 9);
      if (tail < 6)
         drive_line(fx, fy, tx, ty, n);
      else if (tail < 9)
         drive_line(fx, fy, tx, ty, n + $urandom_range(1, 3));
      else
         drive_line(fx, fy, tx, ty, $urandom_range(0, n));
   endtask

   initial begin
      int roll;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed lines: advance before any start, degenerate line, full
      // diagonals, each stepping direction, walked past the end
      send_item(OP_ADVANCE, rand_payload());
      drive_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1);
      drive_line(0, 0, COORD_MAX, COORD_MAX, 1);
      drive_line(COORD_MAX, 0, 0, COORD_MAX, 1);
      drive_line(10, 10, 13, 11, 4);
      drive_line(20, 20, 19, 17, 4);
      drive_line(5, 5, 5, 7, 3);
      drive_line(COORD_MAX, 9, COORD_MAX - 2, 9, 3);

      // Random part: mostly well-formed lines, some long ones cut short,
      // some noise
      while (items_sent < ITEM_GOAL) begin
         if ($urandom_range(0, 19) == 0) no_idle <= !no_idle;
         roll = $urandom_range(0, 99);
         if (roll < 72) begin
            short_line();
         end else if (roll < 84) begin
            drive_line(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                       $urandom_range(1, 40));
         end else begin
            repeat ($urandom_range(1, 6))
               send_item(bls_op_type'($urandom_range(0, 1)), rand_payload());
         end
      end
      req_tvalid <= 1'b0;

      // Drain outstanding pixels, then watch for strays
      while (pixels_pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fault_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
